// ===== rtl/chh_pkg.sv =====
package chh_pkg;

  localparam int NumTimers = 5;

  localparam logic [3:0] LINE_LREQ   = 4'h1;
  localparam logic [3:0] LINE_UREQ   = 4'h2;
  localparam logic [3:0] LINE_READY  = 4'h4;
  localparam logic [3:0] LINE_HOAVBL = 4'h8;
  localparam logic [3:0] LINES_INIT  = LINE_HOAVBL;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // asserted-line patterns (active high after inversion)
  localparam logic [4:0] DI_IDLE     = 5'h00;
  localparam logic [4:0] DI_CS       = 5'h02;
  localparam logic [4:0] DI_CS_VALID = 5'h03;
  localparam logic [4:0] DI_TR_REQ   = 5'h07;
  localparam logic [4:0] DI_BUSY     = 5'h0F;
  localparam logic [4:0] DI_COMPT    = 5'h13;

  localparam logic [2:0] REG_TP1 = 3'd0;
  localparam logic [2:0] REG_TP2 = 3'd1;
  localparam logic [2:0] REG_TP3 = 3'd2;
  localparam logic [2:0] REG_TP4 = 3'd3;
  localparam logic [2:0] REG_TP5 = 3'd4;

  localparam logic [7:0] TP1_RESET = 8'd5;
  localparam logic [7:0] TP2_RESET = 8'd5;
  localparam logic [7:0] TP3_RESET = 8'd121;
  localparam logic [7:0] TP4_RESET = 8'd121;
  localparam logic [7:0] TP5_RESET = 8'd5;

  localparam logic [2:0] ERR_NONE = 3'd0;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_CS_ON    = 4'd1,
    ST_REQ_ON   = 4'd2,
    ST_TP1_RUN  = 4'd3,
    ST_TR_REQ   = 4'd4,
    ST_READY_ON = 4'd5,
    ST_BUSY_ON  = 4'd6,
    ST_REQ_OFF  = 4'd7,
    ST_BUSY_OFF = 4'd8,
    ST_TR_OFF   = 4'd9,
    ST_COMPT_ON = 4'd10,
    ST_TP5_RUN  = 4'd11,
    ST_CS_OFF   = 4'd12,
    ST_DONE     = 4'd13
  } step_t;

  typedef logic [NumTimers-1:0][7:0] timer_vec_t;

  typedef struct packed {
    step_t      step;
    logic [3:0] lines;
    logic [4:0] active;
    timer_vec_t count;
    logic [2:0] error;
  } hs_state_t;

  typedef struct packed {
    logic       op;
    logic [4:0] pins;
    logic       carrier;
  } hs_item_t;

endpackage

// ===== rtl/chh_step.sv =====
module chh_step (
  input  chh_pkg::hs_state_t  cur,
  input  chh_pkg::hs_item_t   item,
  input  chh_pkg::timer_vec_t loads,
  output chh_pkg::hs_state_t  nxt,
  output logic                fired
);
  import chh_pkg::*;

  logic [4:0] di;
  logic [3:0] req;

  always_comb begin
    nxt   = cur;
    fired = 1'b0;
    di    = ~item.pins;
    req   = item.carrier ? LINE_LREQ : LINE_UREQ;
    if (item.op == OP_EVAL) begin
      if (di == DI_IDLE) begin
        nxt.lines = LINES_INIT;
        nxt.step  = ST_IDLE;
      end
      if (di == DI_CS) begin
        if (nxt.step == ST_IDLE) nxt.step = ST_CS_ON;
        if (nxt.step == ST_CS_OFF) nxt.step = ST_DONE;
      end
      if (di == DI_CS_VALID) begin
        if ((nxt.lines & LINE_READY) == 4'h0) begin
          if (nxt.step < ST_REQ_ON) begin
            nxt.step  = ST_REQ_ON;
            nxt.lines = nxt.lines | (item.carrier ? LINE_UREQ : LINE_LREQ);
          end
          if (nxt.step == ST_REQ_ON) begin
            nxt.step = ST_TP1_RUN;
            if (!nxt.active[0]) begin
              nxt.count[0]  = loads[0];
              nxt.active[0] = 1'b1;
            end
          end
        end else begin
          if (nxt.step == ST_BUSY_OFF) nxt.step = ST_TR_OFF;
          if (nxt.step == ST_TP5_RUN) begin
            nxt.step      = ST_CS_OFF;
            nxt.count[4]  = 8'h00;
            nxt.active[4] = 1'b0;
          end
        end
      end
      if (di == DI_TR_REQ) begin
        if (nxt.step == ST_TP1_RUN) begin
          nxt.step      = ST_TR_REQ;
          nxt.count[0]  = 8'h00;
          nxt.active[0] = 1'b0;
        end
        if ((nxt.lines & LINE_READY) == 4'h0) begin
          if (nxt.step == ST_TR_REQ) begin
            nxt.lines = nxt.lines | LINE_READY;
            nxt.step  = ST_READY_ON;
            if (!nxt.active[1]) begin
              nxt.count[1]  = loads[1];
              nxt.active[1] = 1'b1;
            end
          end
        end else if (nxt.step == ST_REQ_OFF) begin
          nxt.step      = ST_BUSY_OFF;
          nxt.count[3]  = 8'h00;
          nxt.active[3] = 1'b0;
        end
      end
      if (di == DI_BUSY) begin
        if (nxt.step == ST_READY_ON) begin
          nxt.step      = ST_BUSY_ON;
          nxt.count[1]  = 8'h00;
          nxt.active[1] = 1'b0;
          if (!nxt.active[2]) begin
            nxt.count[2]  = loads[2];
            nxt.active[2] = 1'b1;
          end
        end
        if (nxt.step == ST_BUSY_ON && (nxt.lines & req) != 4'h0) begin
          nxt.step      = ST_REQ_OFF;
          nxt.count[2]  = 8'h00;
          nxt.active[2] = 1'b0;
          if (!nxt.active[3]) begin
            nxt.count[3]  = loads[3];
            nxt.active[3] = 1'b1;
          end
          nxt.lines = nxt.lines & ~req;
        end
      end
      if (di == DI_COMPT) begin
        if (nxt.step < ST_COMPT_ON) begin
          nxt.step  = ST_COMPT_ON;
          nxt.lines = nxt.lines & ~LINE_READY;
        end
        if (nxt.step == ST_COMPT_ON) begin
          nxt.step = ST_TP5_RUN;
          if (!nxt.active[4]) begin
            nxt.count[4]  = loads[4];
            nxt.active[4] = 1'b1;
          end
        end
      end
    end else begin
      // timers are independent; the highest expiring number wins
      for (int k = 0; k < NumTimers; k++) begin
        if (cur.active[k] && cur.count[k] != 8'h00) begin
          nxt.count[k] = cur.count[k] - 8'h01;
          if (cur.count[k] == 8'h01) begin
            nxt.active[k] = 1'b0;
            nxt.error     = 3'(k + 1);
            nxt.lines     = LINES_INIT;
            nxt.step      = ST_IDLE;
            fired         = 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/carrier_handoff_handshake_top.sv =====
// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | op, pin_levels, carrier_present
// result   | out_valid | out_stall | output_lines, step_now, last_error,
//          |           |           | timeout_fired, timers_running
// config   | psel/penable/pwrite, pready always high | paddr, pwdata, prdata
//
// one request per cycle sustained while the result is not stalled; a request passes
// the input register, then updates the handshake state and result register together
// the state update of one request is seen by the next one in the cycle after
// rst is synchronous: step 0, HO_AVBL only, timers stopped, loads to defaults
// a stalled result holds the result register; the input register then fills
// and in_stall rises until the result is taken
module carrier_handoff_handshake_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [4:0] pin_levels,
  input  logic       carrier_present,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] output_lines,
  output logic [3:0] step_now,
  output logic [2:0] last_error,
  output logic       timeout_fired,
  output logic [4:0] timers_running,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import chh_pkg::*;

  timer_vec_t loads;
  hs_state_t  state;
  hs_state_t  state_next;
  hs_item_t   item;
  logic       item_valid;
  logic       fired_next;
  logic       adv;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loads[REG_TP1] <= TP1_RESET;
      loads[REG_TP2] <= TP2_RESET;
      loads[REG_TP3] <= TP3_RESET;
      loads[REG_TP4] <= TP4_RESET;
      loads[REG_TP5] <= TP5_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_TP1: loads[REG_TP1] <= pwdata[7:0];
        REG_TP2: loads[REG_TP2] <= pwdata[7:0];
        REG_TP3: loads[REG_TP3] <= pwdata[7:0];
        REG_TP4: loads[REG_TP4] <= pwdata[7:0];
        REG_TP5: loads[REG_TP5] <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TP1: prdata = {24'h0, loads[REG_TP1]};
      REG_TP2: prdata = {24'h0, loads[REG_TP2]};
      REG_TP3: prdata = {24'h0, loads[REG_TP3]};
      REG_TP4: prdata = {24'h0, loads[REG_TP4]};
      REG_TP5: prdata = {24'h0, loads[REG_TP5]};
      default: prdata = 32'h0;
    endcase
  end

  // input register
  assign adv      = item_valid && !(out_valid && out_stall);
  assign in_stall = item_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{op: op, pins: pin_levels, carrier: carrier_present};
    end
  end

  chh_step u_step (
    .cur   (state),
    .item  (item),
    .loads (loads),
    .nxt   (state_next),
    .fired (fired_next)
  );

  // handshake state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.step   <= ST_IDLE;
      state.lines  <= LINES_INIT;
      state.active <= 5'h00;
      state.count  <= '0;
      state.error  <= ERR_NONE;
    end else if (adv) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      output_lines   <= state_next.lines;
      step_now       <= state_next.step;
      last_error     <= state_next.error;
      timeout_fired  <= fired_next;
      timers_running <= state_next.active;
    end
  end

  a_fire_inits: assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout_fired |-> step_now == ST_IDLE && output_lines == LINES_INIT
                                   && last_error != ERR_NONE)
    else $error("timeout did not reinitialize handshake");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> step_now <= ST_DONE)
    else $error("step out of range");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    $past(adv) |-> out_valid && step_now == state.step && timers_running == state.active)
    else $error("result register out of step with handshake state");

  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled without a blocked request");

endmodule
